[rtl/dwpi_pkg.sv]
// Shared types, constants and saturating helpers for the dual-wheel PI speed loop.
// Used by dwpi_cfg, dwpi_mac and dual_wheel_pi_speed_loop_top; depends on nothing.
`default_nettype none

package dwpi_pkg;

	// Field widths
	localparam int CNT_W     = 16;
	localparam int EFF_W     = 10;
	localparam int SPD_W     = 24;
	localparam int INTEG_W   = 32;
	localparam int GAIN_W    = 16;
	localparam int MCAND_W   = 32;
	localparam int ACC_W     = 50;
	localparam int BITCNT_W  = 5;

	// Stream and configuration port widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 120;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int EFFORT_LIMIT = 300;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 3'd6;

	// Loop mode codes
	localparam logic MODE_CLOSED = 1'b0;
	localparam logic MODE_OPEN   = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic                     loop_mode;
		logic signed [SPD_W-1:0]  target_speed;
		logic [GAIN_W-1:0]        velocity_scale;
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [GAIN_W-1:0]        steer_gain;
		logic [CNT_W-1:0]         period_ticks;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic sub;
	} mac_ctl_t;

	localparam logic signed [EFF_W-1:0] EFF_MAX = EFF_W'(EFFORT_LIMIT);
	localparam logic signed [EFF_W-1:0] EFF_MIN = -EFF_MAX;
	localparam acc_t ACC_EFF_MAX = acc_t'(EFFORT_LIMIT);
	localparam acc_t ACC_EFF_MIN = -ACC_EFF_MAX;
	localparam acc_t ACC_SPD_MAX = acc_t'(8388607);
	localparam acc_t ACC_SPD_MIN = -ACC_SPD_MAX - acc_t'(1);

	// a - b, clamped to 24 bits
	function automatic logic signed [SPD_W-1:0] sat_sub24(
		input logic signed [SPD_W-1:0] a,
		input logic signed [SPD_W-1:0] b
	);
		logic signed [SPD_W:0] d;
		d = (SPD_W+1)'(a) - (SPD_W+1)'(b);
		if (d[SPD_W] != d[SPD_W-1]) begin
			return d[SPD_W] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
		end
		return d[SPD_W-1:0];
	endfunction

	// Integral plus error, clamped to 32 bits
	function automatic logic signed [INTEG_W-1:0] sat_add32(
		input logic signed [INTEG_W-1:0] a,
		input logic signed [SPD_W-1:0]   b
	);
		logic signed [INTEG_W:0] s;
		s = (INTEG_W+1)'(a) + (INTEG_W+1)'(b);
		if (s[INTEG_W] != s[INTEG_W-1]) begin
			return s[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		end
		return s[INTEG_W-1:0];
	endfunction

	// Divide by 256 toward zero
	function automatic acc_t div256(input acc_t v);
		acc_t t;
		t = v + (v[ACC_W-1] ? acc_t'(255) : acc_t'(0));
		return t >>> 8;
	endfunction

	function automatic logic signed [SPD_W-1:0] div256_sat24(input acc_t v);
		acc_t q;
		q = div256(v);
		if (q > ACC_SPD_MAX) begin
			return ACC_SPD_MAX[SPD_W-1:0];
		end
		if (q < ACC_SPD_MIN) begin
			return ACC_SPD_MIN[SPD_W-1:0];
		end
		return q[SPD_W-1:0];
	endfunction

	function automatic logic signed [EFF_W-1:0] div256_sat_eff(input acc_t v);
		acc_t q;
		q = div256(v);
		if (q > ACC_EFF_MAX) begin
			return EFF_MAX;
		end
		if (q < ACC_EFF_MIN) begin
			return EFF_MIN;
		end
		return q[EFF_W-1:0];
	endfunction

	function automatic logic signed [EFF_W-1:0] sat_eff(input logic signed [EFF_W-1:0] v);
		if (v > EFF_MAX) begin
			return EFF_MAX;
		end
		if (v < EFF_MIN) begin
			return EFF_MIN;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/dwpi_cfg.sv]
// Configuration register file of the dual-wheel PI speed loop.
// Depends on dwpi_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module dwpi_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dwpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dwpi_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dwpi_pkg::cfg_t                        regs
);

	dwpi_pkg::cfg_t regs_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.loop_mode      <= dwpi_pkg::MODE_CLOSED;
			regs_q.target_speed   <= '0;
			regs_q.velocity_scale <= 16'd782;
			regs_q.prop_gain      <= 16'd77;
			regs_q.integ_gain     <= 16'd26;
			regs_q.steer_gain     <= '0;
			regs_q.period_ticks   <= 16'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dwpi_pkg::REG_LOOP_MODE:      regs_q.loop_mode      <= cfg_data[0];
				dwpi_pkg::REG_TARGET_SPEED:   regs_q.target_speed   <= cfg_data;
				dwpi_pkg::REG_VELOCITY_SCALE: regs_q.velocity_scale <= cfg_data[15:0];
				dwpi_pkg::REG_PROP_GAIN:      regs_q.prop_gain      <= cfg_data[15:0];
				dwpi_pkg::REG_INTEG_GAIN:     regs_q.integ_gain     <= cfg_data[15:0];
				dwpi_pkg::REG_STEER_GAIN:     regs_q.steer_gain     <= cfg_data[15:0];
				dwpi_pkg::REG_PERIOD_TICKS:   regs_q.period_ticks   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/dwpi_mac.sv]
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle, shift-and-add.
// Depends on dwpi_pkg for acc_t and mac_ctl_t.
`default_nettype none

module dwpi_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dwpi_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [dwpi_pkg::MCAND_W-1:0]  mcand,
	input  wire logic [dwpi_pkg::GAIN_W-1:0]          mplier,
	output dwpi_pkg::acc_t                            acc,
	output logic                                      done
);

	dwpi_pkg::acc_t                   acc_q;
	dwpi_pkg::acc_t                   mc_q;
	logic [dwpi_pkg::GAIN_W-1:0]      mp_q;
	logic [dwpi_pkg::BITCNT_W-1:0]    cnt_q;
	logic                             sub_q;
	dwpi_pkg::acc_t                   addend;

	// Conditional negate folded into the adder carry
	assign addend = (mc_q ^ {dwpi_pkg::ACC_W{sub_q}}) + dwpi_pkg::acc_t'(sub_q);
	assign acc    = acc_q;
	assign done   = (cnt_q == '0);

	// Load operands, then add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sub_q <= 1'b0;
			acc_q <= '0;
		end else if (ctl.start) begin
			mc_q  <= dwpi_pkg::acc_t'(mcand);
			mp_q  <= mplier;
			cnt_q <= dwpi_pkg::BITCNT_W'(dwpi_pkg::GAIN_W);
			sub_q <= ctl.sub;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else if (cnt_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + addend;
			end
			mc_q  <= mc_q <<< 1;
			mp_q  <= mp_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/dual_wheel_pi_speed_loop_top.sv]
// Top level of the dual-wheel PI speed loop: handshakes, sequencer, loop state.
// Depends on dwpi_pkg, dwpi_cfg and dwpi_mac (one serial MAC per wheel).
//
//  Channel  | Direction | Handshake                    | Contents
//  ---------+-----------+------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready| one 1 ms tick: counts, efforts, halt
//  m_axis   | out       | m_axis_tvalid / m_axis_tready| efforts, speeds, errors, updated flag
//  cfg      | in        | cfg_valid / cfg_ready        | register index and write data
//
// A tick without a period update goes straight to the result; an update runs a velocity
// pass and, in closed mode only, passes for the P, I and steering products. The 16-bit
// serial multiplier in each wheel lane retires one multiplier bit a cycle: one pass for the
// velocity, three for the P, I and steering products. Reset is asynchronous and needs no
// clearing pass. A stalled output holds its item; the next tick is taken and waits in ST_DONE.
`default_nettype none

module dual_wheel_pi_speed_loop_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// count_left[15:0], count_right[31:16], open_effort_left[41:32],
	// open_effort_right[51:42], zero pad[55:52]
	input  wire logic [dwpi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// halt_now[0]
	input  wire logic                                 s_axis_tuser,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// drive_left[9:0], drive_right[19:10], speed_left[43:20], speed_right[67:44],
	// error_left[91:68], error_right[115:92], zero pad[119:116]
	output logic [dwpi_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// updated[0]
	output logic                                      m_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dwpi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dwpi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_VEL  = 7'b0000010,
		ST_ERR  = 7'b0000100,
		ST_MP   = 7'b0001000,
		ST_MI   = 7'b0010000,
		ST_MS   = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	localparam int SPD_W = dwpi_pkg::SPD_W;
	localparam int EFF_W = dwpi_pkg::EFF_W;
	localparam int CNT_W = dwpi_pkg::CNT_W;

	dwpi_pkg::cfg_t regs;
	state_t         state_q;

	// Loop state
	logic [CNT_W-1:0]                    tick_q;
	logic [CNT_W-1:0]                    prev_l_q, prev_r_q;
	logic signed [dwpi_pkg::INTEG_W-1:0] integ_l_q, integ_r_q;
	logic signed [SPD_W-1:0]             vel_l_q, vel_r_q;
	logic signed [EFF_W-1:0]             held_l_q, held_r_q;
	logic signed [SPD_W:0]               lr_q;

	// Latched tick
	logic [CNT_W-1:0]                    cnt_l_q, cnt_r_q;
	logic signed [EFF_W-1:0]             open_l_q, open_r_q;
	logic                                halt_q;
	logic                                upd_q;

	// Output register
	logic                                m_valid_q;
	logic [dwpi_pkg::OUT_TDATA_W-1:0]    m_data_q;
	logic                                m_user_q;

	// Combinational
	logic                                accept;
	logic                                is_open;
	logic [CNT_W-1:0]                    tick_next, period_eff;
	logic                                upd;
	logic signed [CNT_W-1:0]             diff_l, diff_r;
	logic signed [SPD_W-1:0]             err_l_c, err_r_c;
	logic signed [SPD_W-1:0]             out_err_l, out_err_r;
	logic signed [EFF_W-1:0]             held_l_d, held_r_d;
	logic                                out_free;

	dwpi_pkg::mac_ctl_t                  ctl_l, ctl_r;
	logic signed [dwpi_pkg::MCAND_W-1:0] mcand_l, mcand_r;
	logic [dwpi_pkg::GAIN_W-1:0]         mplier;
	dwpi_pkg::acc_t                      acc_l, acc_r;
	logic                                done_l, done_r;

	dwpi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	dwpi_mac u_mac_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_l),
		.mcand  (mcand_l),
		.mplier (mplier),
		.acc    (acc_l),
		.done   (done_l)
	);

	dwpi_mac u_mac_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_r),
		.mcand  (mcand_r),
		.mplier (mplier),
		.acc    (acc_r),
		.done   (done_r)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_open       = (regs.loop_mode == dwpi_pkg::MODE_OPEN);
	assign out_free      = !m_valid_q || m_axis_tready;

	// Tick counting: saturating increment, zero period acts as one
	assign tick_next  = (tick_q == '1) ? tick_q : tick_q + 1'b1;
	assign period_eff = (regs.period_ticks == '0) ? CNT_W'(1) : regs.period_ticks;
	assign upd        = (tick_next >= period_eff);

	// Wrapped count differences
	assign diff_l = s_axis_tdata[15:0] - prev_l_q;
	assign diff_r = s_axis_tdata[31:16] - prev_r_q;

	// Speed errors against the latest velocities
	assign err_l_c   = dwpi_pkg::sat_sub24(regs.target_speed, vel_l_q);
	assign err_r_c   = dwpi_pkg::sat_sub24(regs.target_speed, vel_r_q);
	assign out_err_l = is_open ? '0 : err_l_c;
	assign out_err_r = is_open ? '0 : err_r_c;

	// Next held efforts: closed-loop update, open passthrough, halt last
	always_comb begin
		held_l_d = held_l_q;
		held_r_d = held_r_q;
		if (upd_q && !is_open) begin
			held_l_d = dwpi_pkg::div256_sat_eff(acc_l);
			held_r_d = dwpi_pkg::div256_sat_eff(acc_r);
		end
		if (is_open) begin
			held_l_d = dwpi_pkg::sat_eff(open_l_q);
			held_r_d = dwpi_pkg::sat_eff(open_r_q);
		end
		if (halt_q) begin
			held_l_d = '0;
			held_r_d = '0;
		end
	end

	// Issue MAC passes: velocity, then P, I and steering terms
	always_comb begin
		ctl_l   = '0;
		ctl_r   = '0;
		mcand_l = '0;
		mcand_r = '0;
		mplier  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && upd) begin
					ctl_l   = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
					ctl_r   = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
					mcand_l = dwpi_pkg::MCAND_W'(diff_l);
					mcand_r = dwpi_pkg::MCAND_W'(diff_r);
					mplier  = regs.velocity_scale;
				end
			end
			ST_ERR: begin
				ctl_l   = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
				ctl_r   = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
				mcand_l = dwpi_pkg::MCAND_W'(err_l_c);
				mcand_r = dwpi_pkg::MCAND_W'(err_r_c);
				mplier  = regs.prop_gain;
			end
			ST_MP: begin
				if (done_l) begin
					ctl_l   = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
					ctl_r   = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
					mcand_l = integ_l_q;
					mcand_r = integ_r_q;
					mplier  = regs.integ_gain;
				end
			end
			ST_MI: begin
				if (done_l) begin
					ctl_l   = '{start: 1'b1, clear: 1'b0, sub: 1'b1};
					ctl_r   = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
					mcand_l = dwpi_pkg::MCAND_W'(lr_q);
					mcand_r = dwpi_pkg::MCAND_W'(lr_q);
					mplier  = regs.steer_gain;
				end
			end
			ST_VEL, ST_MS, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tick_q    <= '0;
			prev_l_q  <= '0;
			prev_r_q  <= '0;
			integ_l_q <= '0;
			integ_r_q <= '0;
			vel_l_q   <= '0;
			vel_r_q   <= '0;
			held_l_q  <= '0;
			held_r_q  <= '0;
			upd_q     <= 1'b0;
			halt_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new item, drop it once taken
			m_valid_q <= ((state_q == ST_DONE) && out_free) || (m_valid_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_l_q  <= s_axis_tdata[15:0];
						cnt_r_q  <= s_axis_tdata[31:16];
						open_l_q <= s_axis_tdata[41:32];
						open_r_q <= s_axis_tdata[51:42];
						halt_q   <= s_axis_tuser;
						upd_q    <= upd;
						tick_q   <= upd ? '0 : tick_next;
						state_q  <= upd ? ST_VEL : ST_DONE;
					end
				end
				ST_VEL: begin
					if (done_l) begin
						vel_l_q  <= dwpi_pkg::div256_sat24(acc_l);
						vel_r_q  <= dwpi_pkg::div256_sat24(acc_r);
						prev_l_q <= cnt_l_q;
						prev_r_q <= cnt_r_q;
						state_q  <= is_open ? ST_DONE : ST_ERR;
					end
				end
				ST_ERR: begin
					integ_l_q <= dwpi_pkg::sat_add32(integ_l_q, err_l_c);
					integ_r_q <= dwpi_pkg::sat_add32(integ_r_q, err_r_c);
					lr_q      <= (SPD_W+1)'(vel_l_q) - (SPD_W+1)'(vel_r_q);
					state_q   <= ST_MP;
				end
				ST_MP: begin
					if (done_l) begin
						state_q <= ST_MI;
					end
				end
				ST_MI: begin
					if (done_l) begin
						state_q <= ST_MS;
					end
				end
				ST_MS: begin
					if (done_l) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						held_l_q  <= held_l_d;
						held_r_q  <= held_r_d;
						m_user_q  <= upd_q;
						m_data_q  <= {4'b0, out_err_r, out_err_l, vel_r_q, vel_l_q,
						              held_r_d, held_l_d};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
	// Both wheel lanes run their serial passes in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_l == done_r)
		else $error("wheel MAC lanes out of step");

	// A tick without a period update goes straight to the result
	a_plain_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !upd) |=> (state_q == ST_DONE))
		else $error("plain tick did not go to result");

	// Delivered efforts stay within the effort limit
	a_effort_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed(m_axis_tdata[9:0]) <= dwpi_pkg::EFF_MAX) &&
			($signed(m_axis_tdata[9:0]) >= dwpi_pkg::EFF_MIN) &&
			($signed(m_axis_tdata[19:10]) <= dwpi_pkg::EFF_MAX) &&
			($signed(m_axis_tdata[19:10]) >= dwpi_pkg::EFF_MIN))
		else $error("effort outside limit");
`endif

endmodule

`default_nettype wire
